// File: hdl/lrps_pkg.sv
// Shared types, constants and helpers for the rock-paper-scissors lattice step block.
// No dependencies; imported by lattice_rps_monte_carlo_step_top.
`timescale 1ns / 1ps

package lrps_pkg;

    // Lattice geometry and population
    localparam int GRID_W    = 256;
    localparam int GRID_H    = 256;
    localparam int SPECIES   = 3;
    localparam int PROB_BITS = 16;

    localparam int CELLS     = GRID_W * GRID_H;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COORD_W   = 8;
    localparam int CELL_W    = 2;
    localparam int CNT_W     = 17;
    localparam int TSIZE     = SPECIES * SPECIES;
    localparam int TAB_DEPTH = 2 * TSIZE;
    localparam int TAB_W     = $clog2(TAB_DEPTH);

    // Stream payload widths (tdata padded to whole bytes)
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_PROB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRED_PROB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIDIR     = 2'd2;

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_TABLE  = 2'd1,
        ACT_CELL   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_SWAP  = 3'd1,
        EV_PRED  = 3'd2,
        EV_REPRO = 3'd3,
        EV_TABLE = 3'd4,
        EV_CELL  = 3'd5
    } t_event;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CELL_WR,
        S_READ_B,
        S_CMP_MOVE,
        S_SWAP_WR,
        S_CMP_PRED,
        S_CMP_MODE,
        S_CMP_PROB,
        S_FINISH
    } t_state;

    // Linear lattice address, row major
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
        cell_addr = ADDR_W'(32'(y) * GRID_W + 32'(x));
    endfunction

    // Predation table entry: table, predator 1..SPECIES, prey 1..SPECIES
    function automatic logic [TAB_W-1:0] tab_index(input logic bi,
                                                   input logic [CELL_W-1:0] pred,
                                                   input logic [CELL_W-1:0] prey);
        tab_index = TAB_W'(32'(bi) * TSIZE + (32'(pred) - 1) * SPECIES + 32'(prey) - 1);
    endfunction

    function automatic logic species_ok(input logic [CELL_W-1:0] s);
        species_ok = (s != '0) && (32'(s) <= SPECIES);
    endfunction

endpackage

// File: hdl/lattice_rps_monte_carlo_step_top.sv
// Top level of the rock-paper-scissors lattice step: sequencer, lattice memory,
// species counters, predation tables and the shared comparator. Depends on lrps_pkg.
`timescale 1ns / 1ps

// Usage notes. After reset the block sweeps the 65536-cell lattice to empty, one
// cell per clock, so s_axis_tready stays low until the sweep is done; configuration
// writes are taken at any time (o_cfg_ready is tied high) but must only change
// while no item is in flight. Each input transaction yields exactly one output
// transaction. A table load is written in the decode step; a cell load reads the old
// cell in decode and then writes the new one; an update attempt reads the active cell,
// then the neighbor, and compares mobility. A hit ends in a swap; else it compares the
// predation band: a draw below the band with an occupied neighbor goes on to compare
// table mode and table probability, and a draw at or above it with an empty neighbor
// reproduces. The lattice memory has one read and one write port with a registered
// read, so the active and neighbor cells are read in turn, and a single 17-bit
// comparator evaluates mobility, predation band, table mode and the table probability
// in successive sequencer steps; a swap spends one extra step on its second lattice
// write. The result is loaded as the sequencer returns to idle. The next item is taken
// as soon as the sequencer is back in idle, even while the previous result still waits
// in the output register; only a full output register holds the sequencer at the end.
module lattice_rps_monte_carlo_step_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lrps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lrps_pkg::PROB_BITS-1:0]       i_cfg_data,
    // input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, low bit up: site_x[7:0], site_y[15:8], direction[17:16],
    // action_draw[33:18], mode_draw[49:34], predation_draw[65:50],
    // table_select[66], predator_species[68:67], prey_species[70:69],
    // table_value[86:71], cell_species[88:87], zero pad[95:89]
    input  logic [lrps_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: action[1:0]
    input  logic [lrps_pkg::IN_USER_W-1:0]       s_axis_tuser,
    // results
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata, low bit up: counted[0], generation_end[1], extinct_species[3:2],
    // empty_count[20:4], zero pad[23:21]
    output logic [lrps_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: event_res[2:0]
    output logic [lrps_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
    import lrps_pkg::*;

    // ---------------- state ----------------
    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]       r_cnt [0:SPECIES];
    logic [CNT_W-1:0]       n_cnt [0:SPECIES];
    logic [CNT_W-1:0]       r_events, n_events;

    logic [PROB_BITS-1:0]   r_move_prob, r_pred_prob, r_bidir;

    // Latched input item
    t_action                r_act;
    logic [COORD_W-1:0]     r_x, r_y;
    t_dir                   r_dir;
    logic [PROB_BITS-1:0]   r_adraw, r_mdraw, r_pdraw, r_tval;
    logic                   r_tsel;
    logic [CELL_W-1:0]      r_pred, r_prey, r_csp;

    // Working registers of one attempt
    logic [CELL_W-1:0]      r_a, n_a;      // active cell
    logic [CELL_W-1:0]      r_b, n_b;      // neighbor cell
    t_event                 r_ev, n_ev;
    logic                   r_bi, n_bi;    // bidirectional table chosen

    // Lattice memory
    logic [CELL_W-1:0]      mem_lattice [0:CELLS-1];
    logic [CELL_W-1:0]      r_rdata;
    logic                   mem_we, mem_re;
    logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [CELL_W-1:0]      mem_wdata;

    // Predation tables (contents undefined until loaded)
    logic [PROB_BITS-1:0]   r_ptab [0:TAB_DEPTH-1];
    logic                   tab_we;

    // Output register
    logic                   r_m_valid, n_m_valid;
    t_event                 r_m_ev;
    logic                   r_m_counted, r_m_gen;
    logic [CELL_W-1:0]      r_m_ext;
    logic [CNT_W-1:0]       r_m_empty;
    logic                   out_load, out_free;
    logic                   o_counted, o_gen;
    logic [CELL_W-1:0]      o_ext;

    // Shared comparator
    logic [PROB_BITS:0]     cmp_lhs, cmp_rhs;
    logic                   cmp_lt;
    logic [PROB_BITS:0]     band_top;

    logic                   in_accept, cfg_accept;
    logic [ADDR_W-1:0]      ac_addr, ps_addr;
    logic [COORD_W-1:0]     nb_x, nb_y;
    logic                   in_grid;
    logic [CNT_W:0]         ev_sum;

    assign in_accept  = s_axis_tvalid & s_axis_tready;
    assign cfg_accept = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free   = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_ev;
    assign m_axis_tdata  = {3'b000, r_m_empty, r_m_ext, r_m_gen, r_m_counted};

    // ---------------- addressing ----------------
    assign in_grid = (32'(r_x) < GRID_W) && (32'(r_y) < GRID_H);

    always_comb begin
        nb_x = r_x;
        nb_y = r_y;
        case (r_dir)
            DIR_RIGHT: nb_x = (32'(r_x) == GRID_W - 1) ? '0 : r_x + 1'b1;
            DIR_LEFT:  nb_x = (r_x == '0) ? COORD_W'(GRID_W - 1) : r_x - 1'b1;
            DIR_DOWN:  nb_y = (32'(r_y) == GRID_H - 1) ? '0 : r_y + 1'b1;
            DIR_UP:    nb_y = (r_y == '0) ? COORD_W'(GRID_H - 1) : r_y - 1'b1;
            default:   nb_x = r_x;
        endcase
    end

    assign ac_addr = cell_addr(r_x, r_y);
    assign ps_addr = cell_addr(nb_x, nb_y);

    // ---------------- shared comparator ----------------
    assign band_top = {1'b0, r_move_prob} + {1'b0, r_pred_prob};

    always_comb begin
        cmp_lhs = '0;
        cmp_rhs = '0;
        case (r_state)
            S_CMP_MOVE: begin
                cmp_lhs = {1'b0, r_adraw};
                cmp_rhs = {1'b0, r_move_prob};
            end
            S_CMP_PRED: begin
                cmp_lhs = {1'b0, r_adraw};
                cmp_rhs = band_top;
            end
            S_CMP_MODE: begin
                cmp_lhs = {1'b0, r_mdraw};
                cmp_rhs = {1'b0, r_bidir};
            end
            S_CMP_PROB: begin
                cmp_lhs = {1'b0, r_pdraw};
                cmp_rhs = {1'b0, r_ptab[tab_index(r_bi, r_a, r_b)]};
            end
            default: begin
                cmp_lhs = '0;
                cmp_rhs = '0;
            end
        endcase
    end

    assign cmp_lt = (cmp_lhs < cmp_rhs);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:
                if (r_clr_addr == ADDR_W'(CELLS - 1)) n_state = S_IDLE;
            S_IDLE:
                if (in_accept) n_state = S_DECODE;
            S_DECODE: begin
                n_state = S_FINISH;
                if (r_act == ACT_CELL && in_grid && 32'(r_csp) <= SPECIES)
                    n_state = S_CELL_WR;
                else if (r_act == ACT_UPDATE && in_grid)
                    n_state = S_READ_B;
            end
            S_CELL_WR:
                n_state = S_FINISH;
            S_READ_B:
                n_state = (r_rdata == '0) ? S_FINISH : S_CMP_MOVE;
            S_CMP_MOVE:
                n_state = cmp_lt ? S_SWAP_WR : S_CMP_PRED;
            S_SWAP_WR:
                n_state = S_FINISH;
            S_CMP_PRED:
                n_state = (cmp_lt && r_b != '0) ? S_CMP_MODE : S_FINISH;
            S_CMP_MODE:
                n_state = S_CMP_PROB;
            S_CMP_PROB:
                n_state = S_FINISH;
            S_FINISH:
                if (out_free) n_state = S_IDLE;
            default:
                n_state = S_CLEAR;
        endcase
    end

    // ---------------- datapath controls ----------------
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_cnt      = r_cnt;
        n_events   = r_events;
        n_a        = r_a;
        n_b        = r_b;
        n_ev       = r_ev;
        n_bi       = r_bi;
        n_m_valid  = r_m_valid && !m_axis_tready;
        mem_we     = 1'b0;
        mem_waddr  = ac_addr;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = ac_addr;
        tab_we     = 1'b0;
        out_load   = 1'b0;
        o_counted  = 1'b0;
        o_gen      = 1'b0;
        o_ext      = '0;
        ev_sum     = {1'b0, r_events} + 1'b1;

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_DECODE: begin
                n_ev = EV_NONE;
                if (r_act == ACT_TABLE) begin
                    if (species_ok(r_pred) && species_ok(r_prey)) begin
                        tab_we = 1'b1;
                        n_ev   = EV_TABLE;
                    end
                end else if (in_grid && (r_act == ACT_UPDATE || r_act == ACT_CELL)) begin
                    mem_re = 1'b1;    // old cell for a load, active cell for an attempt
                end
            end
            S_CELL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_csp;
                n_cnt[r_rdata] = n_cnt[r_rdata] - 1'b1;
                n_cnt[r_csp]   = n_cnt[r_csp] + 1'b1;
                n_ev      = EV_CELL;
            end
            S_READ_B: begin
                n_a       = r_rdata;
                mem_re    = (r_rdata != '0);
                mem_raddr = ps_addr;
            end
            S_CMP_MOVE: begin
                n_b = r_rdata;
                if (cmp_lt) begin
                    // swap, first half: neighbor takes the active species
                    mem_we    = 1'b1;
                    mem_waddr = ps_addr;
                    mem_wdata = r_a;
                    n_ev      = EV_SWAP;
                end
            end
            S_SWAP_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_b;
            end
            S_CMP_PRED: begin
                if (!cmp_lt && r_b == '0) begin
                    // reproduction into the empty neighbor
                    mem_we    = 1'b1;
                    mem_waddr = ps_addr;
                    mem_wdata = r_a;
                    n_cnt[r_a] = n_cnt[r_a] + 1'b1;
                    n_cnt[0]   = n_cnt[0] - 1'b1;
                    n_ev      = EV_REPRO;
                end
            end
            S_CMP_MODE: begin
                n_bi = cmp_lt;
            end
            S_CMP_PROB: begin
                if (cmp_lt) begin
                    mem_we    = 1'b1;
                    mem_waddr = ps_addr;
                    n_cnt[r_b] = n_cnt[r_b] - 1'b1;
                    n_cnt[0]   = n_cnt[0] + 1'b1;
                    n_ev      = EV_PRED;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    n_m_valid = 1'b1;
                    if (r_ev == EV_SWAP || r_ev == EV_PRED || r_ev == EV_REPRO) begin
                        o_counted = 1'b1;
                        if (32'(ev_sum) >= CELLS) begin
                            n_events = '0;
                            o_gen    = 1'b1;
                            for (int s = 1; s <= SPECIES; s++)
                                if (r_cnt[s] == '0) o_ext = CELL_W'(s);
                        end else begin
                            n_events = ev_sum[CNT_W-1:0];
                        end
                    end
                end
            end
            default: begin
                n_ev = r_ev;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_events    <= '0;
            r_m_valid   <= 1'b0;
            r_move_prob <= '0;
            r_pred_prob <= '0;
            r_bidir     <= '0;
            r_cnt[0]    <= CNT_W'(CELLS);
            for (int s = 1; s <= SPECIES; s++) r_cnt[s] <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_events   <= n_events;
            r_m_valid  <= n_m_valid;
            r_cnt      <= n_cnt;
            if (cfg_accept) begin
                case (i_cfg_index)
                    REG_MOVE_PROB: r_move_prob <= i_cfg_data;
                    REG_PRED_PROB: r_pred_prob <= i_cfg_data;
                    REG_BIDIR:     r_bidir     <= i_cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_act   <= t_action'(s_axis_tuser);
            r_x     <= s_axis_tdata[7:0];
            r_y     <= s_axis_tdata[15:8];
            r_dir   <= t_dir'(s_axis_tdata[17:16]);
            r_adraw <= s_axis_tdata[33:18];
            r_mdraw <= s_axis_tdata[49:34];
            r_pdraw <= s_axis_tdata[65:50];
            r_tsel  <= s_axis_tdata[66];
            r_pred  <= s_axis_tdata[68:67];
            r_prey  <= s_axis_tdata[70:69];
            r_tval  <= s_axis_tdata[86:71];
            r_csp   <= s_axis_tdata[88:87];
        end
        r_a  <= n_a;
        r_b  <= n_b;
        r_ev <= n_ev;
        r_bi <= n_bi;
        if (out_load) begin
            r_m_ev      <= r_ev;
            r_m_counted <= o_counted;
            r_m_gen     <= o_gen;
            r_m_ext     <= o_ext;
            r_m_empty   <= r_cnt[0];
        end
        if (tab_we) r_ptab[tab_index(r_tsel, r_pred, r_prey)] <= r_tval;
    end

    // Lattice memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) mem_lattice[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem_lattice[mem_raddr];
    end

    // ---------------- assertions ----------------
    // Every cell is counted exactly once across empty and species counters
    a_cnt_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cnt[0]) + 32'(r_cnt[1]) + 32'(r_cnt[2]) + 32'(r_cnt[3])) == CELLS)
        else $error("species counters do not add up to the lattice size");

    // A generation can only end on a counted event
    a_gen_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("generation end without counted event");

    // Lattice is never written while waiting for an item
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("lattice write while idle");

    // Generation counter moves only when a result is loaded
    a_events_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_load |=> $stable(r_events))
        else $error("generation counter changed without a result");

endmodule
